// ===== hw/rtl/trapped_water_two_pointer_unit_assert.svh =====
// Assertion macros used by the trapped-water RTL.
`ifndef TRAPPED_WATER_TWO_POINTER_UNIT_ASSERT_SVH
`define TRAPPED_WATER_TWO_POINTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("twtp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("twtp: next-cycle check failed");

`endif

// ===== hw/rtl/twtp_pkg.sv =====
// Package: sizes, types and sequencer states of the trapped-water unit.
package twtp_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int HEIGHT_BITS = 16;
    localparam int TOTAL_W     = 26;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int CNT_W       = $clog2(MAX_LEN + 1);

    typedef logic [HEIGHT_BITS-1:0] t_height;
    typedef logic [TOTAL_W-1:0]     t_total;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [ADDR_W-1:0]      t_addr;

    // Result of one walk step: new running peak and new total
    typedef struct packed {
        t_height peak;
        t_total  total;
    } t_step_res;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_ACC,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/twtp_step_unit.sv =====
// Shared walk-step unit: saturating water add and running-peak update.
module twtp_step_unit (
    input  twtp_pkg::t_height   i_peak,
    input  twtp_pkg::t_height   i_height,
    input  twtp_pkg::t_total    i_total,
    output twtp_pkg::t_step_res o_res
);
    import twtp_pkg::*;

    logic                 above;
    t_height              diff;
    logic [TOTAL_W:0]     sum;

    // Water over this cell is peak - height when the peak is higher
    assign above = (i_peak > i_height);
    assign diff  = above ? (i_peak - i_height) : '0;
    assign sum   = {1'b0, i_total} + {{(TOTAL_W + 1 - HEIGHT_BITS){1'b0}}, diff};

    // Saturate on carry out of the total width; raise the peak
    always_comb begin
        o_res.total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        o_res.peak  = above ? i_peak : i_height;
    end

endmodule

// ===== hw/rtl/trapped_water_two_pointer_unit.sv =====
// Trapped-water unit: loads a height profile one transaction per cycle while
// in the load state, then walks two pointers inward and returns the
// trapped-water total. Each walk step reads one stored height through the
// registered buffer read port, then passes it through the shared step unit.
// Synchronous active-low reset clears control state; the buffer is not cleared.
module trapped_water_two_pointer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  twtp_pkg::t_height    i_height_value,
    input  logic                 i_last_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output twtp_pkg::t_total     o_water_total,
    output logic                 o_overflow
);
    import twtp_pkg::*;

    `include "trapped_water_two_pointer_unit_assert.svh"

    t_state    r_state, n_state;
    t_count    r_count, n_count;
    logic      r_ovf, n_ovf;
    t_count    r_left, n_left;
    t_count    r_rend, n_rend;
    t_height   r_lpeak, n_lpeak;
    t_height   r_rpeak, n_rpeak;
    t_total    r_acc, n_acc;
    logic      r_side_left, n_side_left;
    logic      r_out_valid, n_out_valid;
    t_total    r_out_total, n_out_total;
    logic      r_out_ovf, n_out_ovf;

    t_height   mem [MAX_LEN];
    t_height   r_rdata;
    t_addr     rd_addr;

    logic      in_acc;
    logic      room;
    t_count    rend_m1;
    t_height   step_peak;
    t_step_res step_res;

    assign o_in_ready    = (r_state == ST_LOAD);
    assign in_acc        = i_in_valid && o_in_ready;
    assign room          = (r_count < CNT_W'(MAX_LEN));
    assign rend_m1       = r_rend - CNT_W'(1);
    assign o_out_valid   = r_out_valid;
    assign o_water_total = r_out_total;
    assign o_overflow    = r_out_ovf;

    // Height buffer: write while loading, registered read for the walk
    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            mem[r_count[ADDR_W-1:0]] <= i_height_value[HEIGHT_BITS-1:0];
        end
        r_rdata <= mem[rd_addr];
    end

    // Shared step unit works on the side that was read
    assign step_peak = r_side_left ? r_lpeak : r_rpeak;

    twtp_step_unit u_step (
        .i_peak   (step_peak),
        .i_height (r_rdata),
        .i_total  (r_acc),
        .o_res    (step_res)
    );

    // Sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_left      = r_left;
        n_rend      = r_rend;
        n_lpeak     = r_lpeak;
        n_rpeak     = r_rpeak;
        n_acc       = r_acc;
        n_side_left = r_side_left;
        n_out_valid = r_out_valid;
        n_out_total = r_out_total;
        n_out_ovf   = r_out_ovf;
        rd_addr     = '0;

        // Result leaves when taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_item) begin
                        n_rend  = room ? (r_count + CNT_W'(1)) : r_count;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                if (r_left < r_rend) begin
                    // Smaller peak advances; ties go to the right side
                    n_side_left = (r_lpeak < r_rpeak);
                    rd_addr     = (r_lpeak < r_rpeak) ? r_left[ADDR_W-1:0]
                                                      : rend_m1[ADDR_W-1:0];
                    n_state     = ST_ACC;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_ACC: begin
                n_acc = step_res.total;
                if (r_side_left) begin
                    n_lpeak = step_res.peak;
                    n_left  = r_left + CNT_W'(1);
                end else begin
                    n_rpeak = step_res.peak;
                    n_rend  = rend_m1;
                end
                n_state = ST_ISSUE;
            end
            ST_DONE: begin
                // Hand off once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_total = r_acc;
                    n_out_ovf   = r_ovf;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_left      = '0;
                    n_rend      = '0;
                    n_lpeak     = '0;
                    n_rpeak     = '0;
                    n_acc       = '0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_left      <= '0;
            r_rend      <= '0;
            r_lpeak     <= '0;
            r_rpeak     <= '0;
            r_acc       <= '0;
            r_side_left <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_left      <= n_left;
            r_rend      <= n_rend;
            r_lpeak     <= n_lpeak;
            r_rpeak     <= n_rpeak;
            r_acc       <= n_acc;
            r_side_left <= n_side_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_total <= n_out_total;
        r_out_ovf   <= n_out_ovf;
    end

    // Buffer fill never passes capacity
    `TWTP_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(MAX_LEN))
    // Drops only happen with a full buffer
    `TWTP_ASSERT_NOW(a_ovf_full, r_ovf, r_count == CNT_W'(MAX_LEN))
    // A step only runs with the pointers still apart
    `TWTP_ASSERT_NOW(a_acc_ptrs, r_state == ST_ACC, r_left < r_rend)
    // Every step returns to the pointer check
    `TWTP_ASSERT_NEXT(a_acc_next, r_state == ST_ACC, r_state == ST_ISSUE)

endmodule
